// ===== hw/rtl/ucsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucsd_pkg
// Types and constants shared by the shift-by-one text decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucsd_pkg;

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  // ascii letters
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5A;
  localparam logic [7:0] ChLoA = 8'h61;
  localparam logic [7:0] ChLoZ = 8'h7A;

  // lead bytes of the two-byte alphabet entries
  localparam logic [7:0] LeadC3 = 8'hC3;
  localparam logic [7:0] LeadD0 = 8'hD0;
  localparam logic [7:0] LeadD1 = 8'hD1;

  // upper alphabet trail bytes
  localparam logic [7:0] UpFirst  = 8'h90;
  localparam logic [7:0] UpIe     = 8'h95;
  localparam logic [7:0] UpZhe    = 8'h96;
  localparam logic [7:0] UpLast   = 8'hAF;
  localparam logic [7:0] UpIoTail = 8'h8B;

  // lower alphabet trail bytes
  localparam logic [7:0] LoFirst  = 8'hB0;
  localparam logic [7:0] LoIe     = 8'hB5;
  localparam logic [7:0] LoZhe    = 8'hB6;
  localparam logic [7:0] LoD0Last = 8'hBF;
  localparam logic [7:0] LoD1Er   = 8'h80;
  localparam logic [7:0] LoLast   = 8'h8F;
  localparam logic [7:0] LoIoTail = 8'h91;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       plain_end;
  } res_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ucsd_text_if.sv =====
// ----------------------------------------------------------------------------
// ucsd_text_if / ucsd_plain_if
// Valid/ready channels for ciphertext bytes in and plaintext bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucsd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface ucsd_plain_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       run_last;
  logic       plain_end;

  modport source (output valid, output plain_byte, output run_last, output plain_end,
                  input ready);
  modport sink   (input valid, input plain_byte, input run_last, input plain_end,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8_caesar_shift_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_caesar_shift_decoder_core
// Undoes a shift-by-one Caesar cipher on a UTF-8 byte stream (latin and
// russian letters).
//
// text_i takes one ciphertext byte per beat, text_end marks the last byte
// of a text. plain_o gives plaintext bytes; run_last flags the last byte
// caused by an input beat, plain_end the final byte of a text.
// An input beat is decoded in the cycle it is accepted, against the byte
// held from the previous beat, and its zero, one or two results are
// written into a 4-entry result queue. Results are registered in the queue
// before they appear on plain_o.
// Throughput is one input beat per cycle while text_i.ready is high,
// that is while the queue has room for two entries; a beat that yields
// two bytes takes two output beats, and the queue absorbs that. So a
// stalled receiver fills the queue and then holds off the sender without
// losing anything. Reset empties the queue and drops any held lead byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_caesar_shift_decoder_core
  import ucsd_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  ucsd_text_if.sink    text_i,
  ucsd_plain_if.source plain_o
);

  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;

  res_entry_t        queue_q [QDepth];
  logic [QAw-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_p1;
  logic [QAw-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QAw:0]      count_q, count_d;

  logic       in_fire, out_fire;
  logic [7:0] b, h;
  logic       fin;
  logic       is_upper, is_lower, starts;
  logic [7:0] f_byte;
  logic       f_emit, f_hold;
  logic       pair_hit;
  logic [7:0] pa, pb;
  logic [1:0] n_res;
  logic [7:0] r0, r1;
  res_entry_t e0, e1;

  assign b   = text_i.text_byte;
  assign fin = text_i.text_end;
  assign h   = held_byte_q;

  assign text_i.ready = (count_q <= (QAw+1)'(QDepth - 2));
  assign in_fire      = text_i.valid & text_i.ready;
  assign plain_o.valid = (count_q != '0);
  assign out_fire     = plain_o.valid & plain_o.ready;

  // fresh byte path
  always_comb begin
    is_upper = (b >= ChUpA) && (b <= ChUpZ);
    is_lower = (b >= ChLoA) && (b <= ChLoZ);
    starts   = (b == LeadC3) || (b == LeadD0) || (b == LeadD1);
    if (b == ChUpA) begin
      f_byte = ChUpZ;
    end else if (b == ChLoA) begin
      f_byte = ChLoZ;
    end else if (is_upper || is_lower) begin
      f_byte = b - 8'd1;
    end else begin
      f_byte = b;
    end
    f_hold = !(is_upper || is_lower) && !fin && starts;
    f_emit = !f_hold;
  end

  // pair lookup against the held lead byte
  always_comb begin
    pair_hit = 1'b0;
    pa       = LeadD0;
    pb       = b - 8'd1;
    if (h == LeadD0 && b >= UpFirst && b <= UpLast) begin
      pair_hit = 1'b1;
      if (b == UpFirst) begin
        pb = UpLast;
      end else if (b == UpZhe) begin
        pa = LeadC3;
        pb = UpIoTail;
      end
    end else if (h == LeadC3 && b == UpIoTail) begin
      pair_hit = 1'b1;
      pb       = UpIe;
    end else if (h == LeadD0 && b >= LoFirst && b <= LoD0Last) begin
      pair_hit = 1'b1;
      if (b == LoFirst) begin
        pa = LeadD1;
        pb = LoLast;
      end else if (b == LoZhe) begin
        pa = LeadD1;
        pb = LoIoTail;
      end
    end else if (h == LeadD1 && b == LoIoTail) begin
      pair_hit = 1'b1;
      pb       = LoIe;
    end else if (h == LeadD1 && b >= LoD1Er && b <= LoLast) begin
      pair_hit = 1'b1;
      if (b == LoD1Er) begin
        pb = LoD0Last;
      end else begin
        pa = LeadD1;
      end
    end
  end

  // result assembly and held byte update
  always_comb begin
    n_res        = 2'd0;
    r0           = f_byte;
    r1           = f_byte;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    if (held_valid_q) begin
      if (pair_hit) begin
        n_res = 2'd2;
        r0    = pa;
        r1    = pb;
      end else begin
        r0    = h;
        n_res = f_emit ? 2'd2 : 2'd1;
      end
    end else begin
      n_res = f_emit ? 2'd1 : 2'd0;
    end
    if (in_fire) begin
      held_valid_d = (!held_valid_q || !pair_hit) && f_hold;
      held_byte_d  = b;
    end
    e0.data      = r0;
    e0.run_last  = (n_res == 2'd1);
    e0.plain_end = (n_res == 2'd1) && fin;
    e1.data      = r1;
    e1.run_last  = 1'b1;
    e1.plain_end = fin;
  end

  // result queue pointers
  always_comb begin
    wr_ptr_p1 = wr_ptr_q + QAw'(1);
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    count_d   = count_q;
    if (in_fire) begin
      wr_ptr_d = wr_ptr_q + QAw'(n_res);
      count_d  = count_d + (QAw+1)'(n_res);
    end
    if (out_fire) begin
      rd_ptr_d = rd_ptr_q + QAw'(1);
      count_d  = count_d - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= e0;
    end
    if (in_fire && n_res == 2'd2) begin
      queue_q[wr_ptr_p1] <= e1;
    end
  end

  assign plain_o.plain_byte = queue_q[rd_ptr_q].data;
  assign plain_o.run_last   = queue_q[rd_ptr_q].run_last;
  assign plain_o.plain_end  = queue_q[rd_ptr_q].plain_end;

endmodule

`default_nettype wire

// ===== test/tb_utf8_caesar_shift_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_caesar_shift_decoder_core
// Self-checking bench for the shift-by-one UTF-8 text decoder.
//
// Ciphertext bytes go in over the text channel with random gaps. Each
// accepted beat runs through a local decoder that keeps its own held lead
// byte and the latin and russian alphabets, and queues the plaintext bytes
// it predicts. Every plaintext beat is checked field by field against the
// oldest queued byte. Directed texts cover the letter wraps, the alphabet
// wraps, the extra letters and broken pairs; a long random part mixes well
// formed pairs with loose bytes, under receiver stalls and sender pauses.
// ----------------------------------------------------------------------------

module tb_utf8_caesar_shift_decoder_core
  import ucsd_pkg::*;
();

  localparam int AbcLen      = 33;
  localparam int TextBeats   = 1700;
  localparam int HoldCycles  = 48;
  localparam int QuietLimit  = 1000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ucsd_text_if  text_if ();
  ucsd_plain_if plain_if ();

  utf8_caesar_shift_decoder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .plain_o (plain_if)
  );

  // alphabets as {lead, trail}
  logic [15:0] upper_abc [AbcLen];
  logic [15:0] lower_abc [AbcLen];

  // decoder state
  logic [7:0] held_lead;
  bit         held_lead_valid;

  res_entry_t plain_expected [$];
  res_entry_t want_beat;
  int         errors;
  int         text_beats;
  bit         src_idle_on;
  bit         snk_idle_on;
  bit         hold_plain_req;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int find_entry(input bit lower, input logic [7:0] a, input logic [7:0] b);
    int k;
    for (k = 0; k < AbcLen; k++) begin
      if ((lower ? lower_abc[k] : upper_abc[k]) == {a, b}) return k;
    end
    return -1;
  endfunction

  function automatic void push_plain(input logic [7:0] data, input bit last, input logic fin);
    res_entry_t r;
    r.data      = data;
    r.run_last  = last;
    r.plain_end = last & fin;
    plain_expected.insert(plain_expected.size(), r);
  endfunction

  // expected plaintext for one accepted ciphertext byte
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] outb [2];
    logic [15:0] prev;
    int n;
    int idx;
    bit fresh;
    n = 0;
    fresh = 1'b1;
    if (held_lead_valid) begin
      held_lead_valid = 1'b0;
      idx = find_entry(1'b0, held_lead, b);
      if (idx >= 0) begin
        prev = upper_abc[(idx + AbcLen - 1) % AbcLen];
      end else begin
        idx = find_entry(1'b1, held_lead, b);
        if (idx >= 0) prev = lower_abc[(idx + AbcLen - 1) % AbcLen];
      end
      if (idx >= 0) begin
        outb[0] = prev[15:8];
        outb[1] = prev[7:0];
        n = 2;
        fresh = 1'b0;
      end else begin
        outb[0] = held_lead;
        n = 1;
      end
    end
    if (fresh) begin
      if ((b >= ChUpA && b <= ChUpZ) || (b >= ChLoA && b <= ChLoZ)) begin
        outb[n] = (b == ChUpA) ? ChUpZ : (b == ChLoA) ? ChLoZ : b - 8'd1;
        n++;
      end else if (!fin && (b == LeadC3 || b == LeadD0 || b == LeadD1)) begin
        held_lead = b;
        held_lead_valid = 1'b1;
      end else begin
        outb[n] = b;
        n++;
      end
    end
    for (int k = 0; k < n; k++) push_plain(outb[k], k == n - 1, fin);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    text_if.text_end  <= fin;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    decode_byte(b, fin);
    text_beats++;
  endtask

  task automatic send_pair(input logic [15:0] pair, input logic fin);
    send_byte(pair[15:8], 1'b0);
    send_byte(pair[7:0], fin);
  endtask

  task automatic wait_drained();
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (plain_expected.size() != 0) @(posedge clk_i);
  endtask

  // mostly well formed letters and pairs, some loose and broken bytes
  task automatic send_random_unit();
    int pick;
    logic [15:0] pair;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pair = $urandom_range(0, 1) ? lower_abc[$urandom_range(0, AbcLen - 1)]
                                  : upper_abc[$urandom_range(0, AbcLen - 1)];
      send_byte(pair[15:8], $urandom_range(0, 40) == 0);
      send_byte(pair[7:0], $urandom_range(0, 11) == 0);
    end else if (pick < 75) begin
      send_byte($urandom_range(0, 1) ? ChUpA + 8'($urandom_range(0, 25))
                                     : ChLoA + 8'($urandom_range(0, 25)),
                $urandom_range(0, 11) == 0);
    end else if (pick < 92) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    end else begin
      pick = $urandom_range(0, 2);
      send_byte(pick == 0 ? LeadC3 : pick == 1 ? LeadD0 : LeadD1, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic test_latin_letters();
    send_byte(ChUpA, 1'b0);
    send_byte(ChUpZ, 1'b0);
    send_byte(ChLoA, 1'b0);
    send_byte(ChLoZ, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_alphabet_wrap();
    send_pair(upper_abc[0], 1'b0);
    send_pair(upper_abc[6], 1'b0);
    send_pair(upper_abc[7], 1'b0);
    send_pair(lower_abc[0], 1'b0);
    send_pair(lower_abc[6], 1'b1);
    send_pair(lower_abc[7], 1'b0);
    wait_drained();
  endtask

  task automatic test_broken_pairs();
    send_byte(LeadD0, 1'b0);
    send_byte(ChUpA, 1'b0);
    send_byte(LeadC3, 1'b1);
    send_byte(LeadD1, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(LeadD0, 1'b0);
    send_byte(LeadD1, 1'b0);
    send_byte(LoLast, 1'b1);
    wait_drained();
  endtask

  task automatic test_receiver_backpressure();
    src_idle_on = 1'b0;
    hold_plain_req = 1'b1;
    repeat (24) send_random_unit();
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_random_unit();
    wait_drained();
    repeat (20) send_random_unit();
    wait_drained();
  endtask

  task automatic test_random_text();
    int mode;
    while (text_beats < TextBeats) begin
      mode = $urandom_range(0, 3);
      src_idle_on = mode[0] | (mode == 0);
      snk_idle_on = mode[1] | (mode == 0);
      repeat (50) send_random_unit();
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    wait_drained();
  endtask

  // plaintext receiver
  initial begin
    int stall;
    plain_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 3) : 0;
      if (hold_plain_req) begin
        plain_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_plain_req = 1'b0;
      end else if (stall > 0) begin
        plain_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      plain_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!plain_if.valid) @(posedge clk_i);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (plain_if.valid && plain_if.ready) begin
      if (plain_expected.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual byte %h run_last %b plain_end %b",
                 $time, plain_if.plain_byte, plain_if.run_last, plain_if.plain_end);
        errors++;
      end else begin
        want_beat = plain_expected.pop_front();
        if (plain_if.plain_byte !== want_beat.data) begin
          $display("%0t: plain_byte expected %h actual %h",
                   $time, want_beat.data, plain_if.plain_byte);
          errors++;
        end
        if (plain_if.run_last !== want_beat.run_last) begin
          $display("%0t: run_last expected %b actual %b",
                   $time, want_beat.run_last, plain_if.run_last);
          errors++;
        end
        if (plain_if.plain_end !== want_beat.plain_end) begin
          $display("%0t: plain_end expected %b actual %b",
                   $time, want_beat.plain_end, plain_if.plain_end);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((text_if.valid && text_if.ready) || (plain_if.valid && plain_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int k = 0; k < AbcLen; k++) begin
      if (k < 6) begin
        upper_abc[k] = {LeadD0, UpFirst + 8'(k)};
        lower_abc[k] = {LeadD0, LoFirst + 8'(k)};
      end else if (k == 6) begin
        upper_abc[k] = {LeadC3, UpIoTail};
        lower_abc[k] = {LeadD1, LoIoTail};
      end else begin
        upper_abc[k] = {LeadD0, UpZhe + 8'(k - 7)};
        lower_abc[k] = (k < 17) ? {LeadD0, LoZhe + 8'(k - 7)} : {LeadD1, LoD1Er + 8'(k - 17)};
      end
    end
    held_lead       = 8'h00;
    held_lead_valid = 1'b0;
    errors          = 0;
    text_beats      = 0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    hold_plain_req  = 1'b0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= 8'h00;
    text_if.text_end  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_latin_letters();
    test_alphabet_wrap();
    test_broken_pairs();
    test_receiver_backpressure();
    test_sender_pause();
    test_random_text();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
